[sv/sha256_pkg.sv]
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  widx_t;

  // Input item commands
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_AT      = 56;
  localparam byte_t       PAD_MARK    = 8'h80;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

[sv/sha256_if.sv]
// Handshake channels of the SHA-256 stream hasher: byte input and digest output.
// Depends on sha256_pkg for payload types.
`timescale 1ns / 1ps

interface sha256_in_if;
  import sha256_pkg::*;
  logic  valid;
  logic  ready;
  logic  command;
  byte_t data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha256_out_if;
  import sha256_pkg::*;
  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[sv/sha256_stream_hasher.sv]
// SHA-256 stream hasher top level: byte intake, padding sequencer, round unit, digest bank.
// Depends on sha256_pkg and the channel interfaces in sha256_if.sv.
`timescale 1ns / 1ps

// Feed the message one byte per item with command low; send an item with command high to
// pad and finish, after which the eight digest words leave the output channel, word 0 first,
// last_word marking the eighth. The 64th byte of a block also starts a compression: 64
// rounds through the single round unit, then 8 fold steps in which one adder folds the
// working words into the chaining words; the input is not ready until these are done. A
// finish shifts in padding at one byte per cycle up to the block end, runs one compression
// (two when the 0x80 mark lands at byte 56 or later) and hands the digest to the output
// bank; the input is then ready for the next message while the bank drains at one word
// per cycle whenever the receiver is ready. A finish whose digest is ready before the
// previous digest has drained waits for the bank to empty.
module sha256_stream_hasher (
  input logic          clk,
  input logic          rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [5:0] LAST_BYTE  = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LAST_ROUND = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_POS    = 6'(LEN_AT);

  logic [2:0]   state;
  logic [5:0]   cnt;        // round number, or fold step in its low bits
  logic [5:0]   fill;       // bytes of the current block already shifted in
  logic [63:0]  msg_bytes;
  logic         in_pad;     // finishing a message
  logic         mark_done;  // 0x80 already placed
  logic         len_here;   // this block carries the length field
  logic         final_blk;  // compression under way is the last of the message

  // Block buffer and message schedule share one 512-bit shift line:
  // bytes enter at the bottom, rounds take W[t] from the top.
  logic [511:0] blk;
  word_t        chain [8];
  word_t        wv    [8];

  word_t        dig [8];
  widx_t        dig_idx;
  logic         dig_busy;

  // Datapath terms
  word_t  w0, w1, w9, w14, w_new, t1, t2, ch, maj;
  logic   len_eff;
  byte_t  pad_byte;
  logic [63:0] len_bits;
  logic   take_byte;

  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1  = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[cnt] + w0;
  assign t2  = big_sigma0(wv[0]) + maj;

  // Length field goes in the block where the mark fell before byte 56, or in the extra block
  assign len_eff  = mark_done ? len_here : (fill < LEN_POS);
  assign len_bits = {msg_bytes[60:0], 3'b000};

  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (len_here && (fill >= LEN_POS)) begin
      pad_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign take_byte   = in_ch.valid && in_ch.ready && (in_ch.command == CMD_DATA);

  // Sequencer and compression datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      fill      <= '0;
      msg_bytes <= '0;
      in_pad    <= 1'b0;
      mark_done <= 1'b0;
      len_here  <= 1'b0;
      final_blk <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.command == CMD_FINISH) begin
              // start padding; any data byte on this item is dropped
              in_pad    <= 1'b1;
              mark_done <= 1'b0;
              len_here  <= 1'b0;
              state     <= ST_PAD;
            end else begin
              blk       <= {blk[503:0], in_ch.data_byte};
              fill      <= fill + 6'd1;
              msg_bytes <= msg_bytes + 64'd1;
              if (fill == LAST_BYTE) begin
                for (int i = 0; i < 8; i++) wv[i] <= chain[i];
                final_blk <= 1'b0;
                cnt       <= '0;
                state     <= ST_ROUND;
              end
            end
          end
        end
        ST_PAD: begin
          blk       <= {blk[503:0], pad_byte};
          fill      <= fill + 6'd1;
          mark_done <= 1'b1;
          len_here  <= len_eff;
          if (fill == LAST_BYTE) begin
            for (int i = 0; i < 8; i++) wv[i] <= chain[i];
            final_blk <= len_eff;
            cnt       <= '0;
            state     <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          blk   <= {blk[479:0], w_new};
          wv[0] <= t1 + t2;
          wv[1] <= wv[0];
          wv[2] <= wv[1];
          wv[3] <= wv[2];
          wv[4] <= wv[3] + t1;
          wv[5] <= wv[4];
          wv[6] <= wv[5];
          wv[7] <= wv[6];
          if (cnt == LAST_ROUND) begin
            cnt   <= '0;
            state <= ST_FOLD;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_FOLD: begin
          // rotate both banks through one adder; after eight steps they are back in order
          for (int i = 0; i < 7; i++) begin
            chain[i] <= chain[i+1];
            wv[i]    <= wv[i+1];
          end
          chain[7] <= chain[0] + wv[0];
          wv[7]    <= wv[0];
          if (cnt[2:0] == 3'd7) begin
            cnt <= '0;
            if (final_blk) begin
              state <= ST_DONE;
            end else if (in_pad) begin
              len_here <= 1'b1;
              state    <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_DONE: begin
          // hold until the digest bank is free, then restart for the next message
          if (!dig_busy) begin
            for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
            msg_bytes <= '0;
            fill      <= '0;
            in_pad    <= 1'b0;
            mark_done <= 1'b0;
            len_here  <= 1'b0;
            final_blk <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digest bank: drains one word per output item, independent of the intake side
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_busy <= 1'b0;
      dig_idx  <= '0;
    end else if (state == ST_DONE && !dig_busy) begin
      for (int i = 0; i < 8; i++) dig[i] <= chain[i];
      dig_idx  <= '0;
      dig_busy <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      for (int i = 0; i < 7; i++) dig[i] <= dig[i+1];
      dig_idx <= dig_idx + 3'd1;
      if (dig_idx == 3'd7) begin
        dig_busy <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = dig_busy;
  assign out_ch.digest_word = dig[0];
  assign out_ch.word_index  = dig_idx;
  assign out_ch.last_word   = (dig_idx == 3'd7);

  // Checks
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == LAST_ROUND) |=> (state == ST_FOLD))
    else $error("compression did not move to fold after the last round");

  a_done_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (fill == 6'd0 && in_pad && mark_done))
    else $error("digest ready with a partial block or without padding");

  a_last_word_drains: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
    else $error("digest bank reloaded in the cycle after its last word");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    take_byte |-> (state == ST_IDLE && !final_blk))
    else $error("data byte taken outside intake");

endmodule

[tb/sv/sha256_stream_hasher_tb.sv]
// Self-checking testbench for the SHA-256 stream hasher: byte items in, digest words out.
// Depends on sha256_pkg for payload types and on sha256_if.sv for the channel interfaces.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  import sha256_pkg::*;

  // Padding layout: marker byte, zeros, then the bit length from this offset on.
  localparam byte_t       PAD_BYTE   = 8'h80;
  localparam int unsigned LEN_OFFSET = 56;
  localparam int unsigned BLK_SIZE   = 64;

  // Give up after this many cycles in which neither channel moves an item. The slowest
  // legal stretch is a finish that needs two compressions, plus a stalled receiver; take
  // a wide margin over that.
  localparam int unsigned QUIET_LIMIT  = 2000;
  // Settle time once nothing is outstanding: two compressions and a padding pass.
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned MAX_REPORTS  = 10;

  // Opening message length of the sender-idle and receiver-stall phases: the mark lands
  // on byte 56 (spills into a second block), and a full block followed by a finish on an
  // empty buffer.
  localparam int unsigned EDGE_LEN [2] = '{56, 64};

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic  cmd;
    byte_t data;
  } byte_item_t;

  typedef struct packed {
    word_t word;
    widx_t idx;
    logic  last;
  } digest_exp_t;

  logic clk;
  logic rst;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_stream_hasher u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting for the driver, and digest words still owed by the block.
  byte_item_t  send_q [$];
  digest_exp_t digest_due [$];
  byte_item_t  next_item;
  digest_exp_t want_word;

  idle_mode_t  idle_mode;

  // Running hash state, advanced on every accepted item.
  word_t       hash_chain [8];
  byte_t       block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_byte_count;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned bytes_hashed;
  int unsigned msgs_hashed;
  int unsigned quiet_cycles;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of block_bytes into hash_chain.
  function automatic void sha_compress();
    word_t sched [64];
    word_t wv [8];
    word_t t1;
    word_t t2;
    int    i;
    for (i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      sched[i] = sched[i-16] + sched[i-7]
               + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
    end
    wv = hash_chain;
    for (i = 0; i < 64; i++) begin
      t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
         + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + SHA_K[i] + sched[i];
      t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      wv[7] = wv[6];
      wv[6] = wv[5];
      wv[5] = wv[4];
      wv[4] = wv[3] + t1;
      wv[3] = wv[2];
      wv[2] = wv[1];
      wv[1] = wv[0];
      wv[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      hash_chain[i] = hash_chain[i] + wv[i];
    end
  endfunction

  // Advance the hash by one accepted item; a finish pads, closes the message and
  // queues the eight digest words it must produce.
  function automatic void sha_absorb(logic cmd, byte_t b);
    logic [63:0] bit_len;
    int unsigned pos;
    int          i;
    if (cmd == CMD_DATA) begin
      block_bytes[block_fill] = b;
      block_fill++;
      msg_byte_count++;
      bytes_hashed++;
      if (block_fill == BLK_SIZE) begin
        sha_compress();
        block_fill = 0;
      end
      return;
    end
    // The data byte of a finish is ignored.
    bit_len = msg_byte_count << 3;
    pos = block_fill;
    block_bytes[pos] = PAD_BYTE;
    pos++;
    // No room for the length: zero the rest and spill into a second block.
    if (pos > LEN_OFFSET) begin
      while (pos < BLK_SIZE) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < LEN_OFFSET) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) begin
      block_bytes[LEN_OFFSET + i] = bit_len[8*(7-i) +: 8];
    end
    sha_compress();
    for (i = 0; i < 8; i++) begin
      digest_due.push_back('{hash_chain[i], widx_t'(i), (i == 7)});
    end
    hash_chain     = SHA_IV;
    block_fill     = 0;
    msg_byte_count = '0;
    msgs_hashed++;
  endfunction

  function automatic void log_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // Decide whether one side holds off this cycle under the current idling phase.
  function automatic bit roll_stall(bit side_active);
    int unsigned pct;
    pct = (idle_mode == IDLE_BOTH) ? 30 : 69;
    return side_active && ($urandom_range(99) < pct);
  endfunction

  task automatic push_item(logic cmd, byte_t b);
    send_q.push_back('{cmd, b});
  endtask

  // Clock, and every block input at a known level from time zero.
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_DATA;
    in_ch.data_byte  = 8'h00;
    out_ch.ready     = 1'b0;
    idle_mode        = IDLE_NONE;
    hash_chain       = SHA_IV;
    block_fill       = 0;
    msg_byte_count   = '0;
    mismatches       = 0;
    words_checked    = 0;
    bytes_hashed     = 0;
    msgs_hashed      = 0;
    forever #5 clk = ~clk;
  end

  // Driver: present the next queued item once the current one is taken, or hold off
  // at random while the sender is idling. Prediction runs on the item accepted here.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sha_absorb(in_ch.command, in_ch.data_byte);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_q.size() != 0 &&
            !roll_stall(idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)) begin
          next_item = send_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.command   <= next_item.cmd;
          in_ch.data_byte <= next_item.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: drop ready at random while the receiver is stalling.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !roll_stall(idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH);
    end
  end

  // Monitor: match each digest word against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (digest_due.size() == 0) begin
        log_error($sformatf("unexpected digest word %08h index %0d last %0b",
                            out_ch.digest_word, out_ch.word_index, out_ch.last_word));
      end else begin
        want_word = digest_due.pop_front();
        words_checked++;
        if (out_ch.digest_word !== want_word.word || out_ch.word_index !== want_word.idx ||
            out_ch.last_word !== want_word.last) begin
          log_error($sformatf("digest word: expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
                              want_word.word, want_word.idx, want_word.last,
                              out_ch.digest_word, out_ch.word_index, out_ch.last_word));
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] ERROR: no item moved for %0d cycles, %0d digest words outstanding",
               $realtime, QUIET_LIMIT, digest_due.size());
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  // Stimulus. Queue filling and idle-mode changes happen on the falling edge so they
  // never race the clocked driver and monitor.
  initial begin
    int unsigned ph;
    int unsigned len;
    int unsigned k;
    int unsigned phase_items;
    int unsigned phase_msgs;

    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message with a non-zero byte on the finish (byte must be ignored),
    // a second empty message back to back, single extreme bytes, and "abc".
    push_item(CMD_FINISH, 8'hff);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_DATA,   8'h00);
    push_item(CMD_FINISH, 8'h5a);
    push_item(CMD_DATA,   8'hff);
    push_item(CMD_FINISH, 8'hff);
    push_item(CMD_DATA,   8'h61);
    push_item(CMD_DATA,   8'h62);
    push_item(CMD_DATA,   8'h63);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_DATA,   8'h80);
    push_item(CMD_DATA,   8'h01);
    push_item(CMD_FINISH, 8'ha5);
    while (send_q.size() != 0 || in_ch.valid || digest_due.size() != 0) @(negedge clk);

    // Random messages, one idling phase at a time. The sender-idle and receiver-stall
    // phases open with a padding-boundary length; the rest are short random messages.
    for (ph = 0; ph < 4; ph++) begin
      idle_mode   = idle_mode_t'(ph);
      phase_items = 0;
      phase_msgs  = 0;
      while (phase_items < 8) begin
        if (phase_msgs == 0 && (ph == 1 || ph == 2)) begin
          len = EDGE_LEN[ph-1];
        end else begin
          len = $urandom_range(6);
        end
        for (k = 0; k < len; k++) begin
          push_item(CMD_DATA, byte_t'($urandom_range(255)));
        end
        push_item(CMD_FINISH, byte_t'($urandom_range(255)));
        phase_items += len + 1;
        phase_msgs++;
      end
      // Hold the sender until every digest word of this phase has come back.
      while (send_q.size() != 0 || in_ch.valid || digest_due.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Hashed %0d messages (%0d data bytes), checked %0d digest words.",
             msgs_hashed, bytes_hashed, words_checked);
    $display("Covered empty messages, a padding spill at 56 bytes and a full 64-byte block "
             , "under four flow-control patterns.");
    if (mismatches == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_stream_hasher.sv
tb/sv/sha256_stream_hasher_tb.sv
